### rtl/rbu_pkg.sv
// Shared types, constants and channel blend functions for the 2x bilinear upscaler.
`default_nettype none
package rbu_pkg;

  localparam int PIX_W    = 24;
  localparam int CH_W     = 8;
  localparam int NUM_CH   = 3;
  localparam int COORD_W  = 11;
  localparam int CFG_W    = 11;
  localparam int REG_IDX_W = 1;
  localparam int OUT_DATA_W = 48;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd1024;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd1024;

  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  // One-hot codes of the four block kinds, lowest sent first.
  localparam logic [3:0] BLK_INNER  = 4'b0001;
  localparam logic [3:0] BLK_RIGHT  = 4'b0010;
  localparam logic [3:0] BLK_BOTTOM = 4'b0100;
  localparam logic [3:0] BLK_CORNER = 4'b1000;

  // Blocks that one source pixel completes.
  typedef struct packed {
    logic corner;
    logic bottom;
    logic right;
    logic inner;
  } blk_flags_t;

  // Truncating average of two pixels, per channel.
  function automatic logic [PIX_W-1:0] blend2(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b);
    logic [PIX_W-1:0] res;
    logic [CH_W:0]    sum;
    res = '0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      sum = {1'b0, a[ch*CH_W +: CH_W]} + {1'b0, b[ch*CH_W +: CH_W]};
      res[ch*CH_W +: CH_W] = sum[CH_W:1];
    end
    return res;
  endfunction

  // Truncating average of four pixels, per channel.
  function automatic logic [PIX_W-1:0] blend4(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b,
                                              input logic [PIX_W-1:0] d,
                                              input logic [PIX_W-1:0] e);
    logic [PIX_W-1:0] res;
    logic [CH_W+1:0]  sum;
    res = '0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      sum = {2'b00, a[ch*CH_W +: CH_W]} + {2'b00, b[ch*CH_W +: CH_W]}
          + {2'b00, d[ch*CH_W +: CH_W]} + {2'b00, e[ch*CH_W +: CH_W]};
      res[ch*CH_W +: CH_W] = sum[CH_W+1:2];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

### rtl/rgb_bilinear_upscale_2x_top.sv
// Top level of the streaming 2x bilinear RGB upscaler.
//
//  channel   dir  handshake                  payload
//  s_axis    in   s_axis_tvalid/tready       tdata[23:0] in_pixel
//  m_axis    out  m_axis_tvalid/tready       tdata out_x, out_y, out_pixel; tlast last_of_run
//  cfg       in   cfg_we                     cfg_addr register index, cfg_wdata value
//
// An inner pixel yields one 2x2 block, four outputs at one per cycle while the output
// is not stalled, so the output register sets the pace; edge pixels yield up to 16 outputs.
// The first output passes the stage register and line store read, then the block
// sequencer, then the output register. The line store needs no clearing pass: reset
// clears the counters, neighbor registers and valid flags. A stalled output holds the
// sequencer, which holds one staged pixel and then drops s_axis_tready.
`default_nettype none
module rgb_bilinear_upscale_2x_top #(
  parameter int MAX_WIDTH  = rbu_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rbu_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [rbu_pkg::PIX_W-1:0]         s_axis_tdata,  // [23:0] in_pixel
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [10:0] out_x, [21:11] out_y, [45:22] out_pixel, [47:46] zero
  output logic [rbu_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
  output logic                                   m_axis_tlast,
  input  wire logic                              cfg_we,
  input  wire logic [rbu_pkg::REG_IDX_W-1:0]     cfg_addr,
  input  wire logic [rbu_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int WCW = (WW > rbu_pkg::CFG_W) ? WW : rbu_pkg::CFG_W;
  localparam int HCW = (HW > rbu_pkg::CFG_W) ? HW : rbu_pkg::CFG_W;

  logic [rbu_pkg::CFG_W-1:0] image_width;
  logic [rbu_pkg::CFG_W-1:0] image_height;
  logic [CW-1:0]             column_count;
  logic [RW-1:0]             row_count;
  logic [rbu_pkg::PIX_W-1:0] left_pixel;
  logic [rbu_pkg::PIX_W-1:0] left_above_pixel;

  logic                      s1_valid;
  logic [rbu_pkg::PIX_W-1:0] s1_cur;
  logic [CW-1:0]             s1_col;
  logic [RW-1:0]             s1_row;
  rbu_pkg::blk_flags_t       s1_flags;
  logic [rbu_pkg::PIX_W-1:0] s1_above;

  logic [WW-1:0]             w_eff;
  logic [HW-1:0]             h_eff;
  logic                      col_last;
  logic                      row_last;
  logic                      accept;
  logic                      s1_go;
  logic                      emit_ready;
  rbu_pkg::blk_flags_t       flags_next;
  logic [rbu_pkg::COORD_W-1:0] out_x;
  logic [rbu_pkg::COORD_W-1:0] out_y;
  logic [rbu_pkg::PIX_W-1:0]   out_pixel;

  // Zero acts as one, anything above the maximum acts as the maximum.
  always_comb begin
    if (image_width == '0) begin
      w_eff = WW'(1);
    end else if (WCW'(image_width) > WCW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(image_width);
    end
    if (image_height == '0) begin
      h_eff = HW'(1);
    end else if (HCW'(image_height) > HCW'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(image_height);
    end
  end

  assign col_last = (WW'(column_count) == w_eff - WW'(1));
  assign row_last = (HW'(row_count) == h_eff - HW'(1));

  assign flags_next.inner  = (row_count != '0) && (column_count != '0);
  assign flags_next.right  = (row_count != '0) && col_last;
  assign flags_next.bottom = row_last && (column_count != '0);
  assign flags_next.corner = row_last && col_last;

  assign s1_go         = s1_valid && emit_ready;
  assign s_axis_tready = !s1_valid || s1_go;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= rbu_pkg::WIDTH_RESET;
      image_height <= rbu_pkg::HEIGHT_RESET;
      column_count <= '0;
      row_count    <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        rbu_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_wdata;
        rbu_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_wdata;
        default: begin
        end
      endcase
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      // Advance raster position, wrap at end of row and frame.
      if (col_last) begin
        column_count <= '0;
        row_count    <= row_last ? '0 : row_count + RW'(1);
      end else begin
        column_count <= column_count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cur   <= s_axis_tdata;
      s1_col   <= column_count;
      s1_row   <= row_count;
      s1_flags <= flags_next;
    end
  end

  // Neighbor pixels move on as the staged pixel hands off to the sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      left_pixel       <= '0;
      left_above_pixel <= '0;
    end else if (s1_go) begin
      left_pixel       <= s1_cur;
      left_above_pixel <= s1_above;
    end
  end

  rbu_line_buf #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_buf (
    .clk   (clk),
    .en    (accept),
    .addr  (column_count),
    .wdata (s_axis_tdata),
    .rdata (s1_above)
  );

  rbu_emit #(
    .CW (CW),
    .RW (RW)
  ) u_emit (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (s1_valid),
    .req_ready      (emit_ready),
    .req_flags      (s1_flags),
    .req_col        (s1_col),
    .req_row        (s1_row),
    .req_left_above (left_above_pixel),
    .req_above      (s1_above),
    .req_left       (left_pixel),
    .req_cur        (s1_cur),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .out_x          (out_x),
    .out_y          (out_y),
    .out_pixel      (out_pixel),
    .out_last       (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, out_pixel, out_y, out_x};

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    WW'(column_count) < w_eff)
    else $error("column counter beyond image width");

  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    HW'(row_count) < h_eff)
    else $error("row counter beyond image height");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !emit_ready) |=> (s1_valid && $stable(s1_cur) && $stable(s1_above)))
    else $error("staged pixel or line store data lost while sequencer busy");

endmodule
`default_nettype wire

### rtl/rbu_line_buf.sv
// Single-port line store with registered read data, read-before-write.
`default_nettype none
module rbu_line_buf #(
  parameter int DEPTH = rbu_pkg::DEF_MAX_WIDTH,
  parameter int AW    = $clog2(rbu_pkg::DEF_MAX_WIDTH)
) (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire logic [AW-1:0]             addr,
  input  wire logic [rbu_pkg::PIX_W-1:0] wdata,
  output logic      [rbu_pkg::PIX_W-1:0] rdata
);

  logic [rbu_pkg::PIX_W-1:0] mem [DEPTH];

  // Return the previous row's pixel and store the current one in the same cycle.
  always_ff @(posedge clk) begin
    if (en) begin
      rdata     <= mem[addr];
      mem[addr] <= wdata;
    end
  end

endmodule
`default_nettype wire

### rtl/rbu_emit.sv
// Block sequencer: walks the completed blocks of one pixel and drives the output register.
`default_nettype none
module rbu_emit #(
  parameter int CW = $clog2(rbu_pkg::DEF_MAX_WIDTH),
  parameter int RW = $clog2(rbu_pkg::DEF_MAX_HEIGHT)
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        req_valid,
  output logic                             req_ready,
  input  wire rbu_pkg::blk_flags_t         req_flags,
  input  wire logic [CW-1:0]               req_col,
  input  wire logic [RW-1:0]               req_row,
  input  wire logic [rbu_pkg::PIX_W-1:0]   req_left_above,
  input  wire logic [rbu_pkg::PIX_W-1:0]   req_above,
  input  wire logic [rbu_pkg::PIX_W-1:0]   req_left,
  input  wire logic [rbu_pkg::PIX_W-1:0]   req_cur,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [rbu_pkg::COORD_W-1:0]      out_x,
  output logic [rbu_pkg::COORD_W-1:0]      out_y,
  output logic [rbu_pkg::PIX_W-1:0]        out_pixel,
  output logic                             out_last
);

  localparam int XW = (CW + 1 > rbu_pkg::COORD_W) ? CW + 1 : rbu_pkg::COORD_W;
  localparam int YW = (RW + 1 > rbu_pkg::COORD_W) ? RW + 1 : rbu_pkg::COORD_W;

  logic                      job_valid;
  logic [3:0]                pend;
  logic [1:0]                sub;
  logic [CW-1:0]             col;
  logic [RW-1:0]             row;
  logic [rbu_pkg::PIX_W-1:0] left_above;
  logic [rbu_pkg::PIX_W-1:0] above;
  logic [rbu_pkg::PIX_W-1:0] left;
  logic [rbu_pkg::PIX_W-1:0] cur;

  logic [3:0]                blk;
  logic [3:0]                pend_next;
  logic                      emit;
  logic                      blk_end;
  logic                      job_done;
  logic                      take;
  logic [rbu_pkg::PIX_W-1:0] pa, pb, pd, pe;
  logic [rbu_pkg::PIX_W-1:0] pix;
  logic [CW-1:0]             bx;
  logic [RW-1:0]             by;
  logic [XW-1:0]             x_wide;
  logic [YW-1:0]             y_wide;

  // Lowest pending block goes first.
  assign blk       = pend & (~pend + 4'd1);
  assign pend_next = pend & ~blk;
  assign emit      = job_valid && (!out_valid || out_ready);
  assign blk_end   = emit && (sub == 2'd3);
  assign job_done  = blk_end && (pend_next == 4'd0);
  assign req_ready = !job_valid || job_done;
  assign take      = req_valid && req_ready;

  always_comb begin
    pa = cur;
    pb = cur;
    pd = cur;
    pe = cur;
    bx = col;
    by = row;
    case (blk)
      rbu_pkg::BLK_INNER: begin
        pa = left_above;
        pb = above;
        pd = left;
        bx = col - CW'(1);
        by = row - RW'(1);
      end
      rbu_pkg::BLK_RIGHT: begin
        pa = above;
        pb = above;
        by = row - RW'(1);
      end
      rbu_pkg::BLK_BOTTOM: begin
        pa = left;
        pd = left;
        bx = col - CW'(1);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    case (sub)
      2'd0:    pix = pa;
      2'd1:    pix = rbu_pkg::blend2(pa, pb);
      2'd2:    pix = rbu_pkg::blend2(pa, pd);
      default: pix = rbu_pkg::blend4(pa, pb, pd, pe);
    endcase
  end

  assign x_wide = XW'({bx, sub[0]});
  assign y_wide = YW'({by, sub[1]});

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      pend      <= 4'd0;
      sub       <= 2'd0;
    end else if (take) begin
      job_valid <= |req_flags;
      pend      <= req_flags;
      sub       <= 2'd0;
    end else if (emit) begin
      sub <= sub + 2'd1;
      if (blk_end) begin
        pend <= pend_next;
      end
      if (job_done) begin
        job_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      col        <= req_col;
      row        <= req_row;
      left_above <= req_left_above;
      above      <= req_above;
      left       <= req_left;
      cur        <= req_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_x     <= x_wide[rbu_pkg::COORD_W-1:0];
      out_y     <= y_wide[rbu_pkg::COORD_W-1:0];
      out_pixel <= pix;
      out_last  <= job_done;
    end
  end

  a_job_has_blocks: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> (pend != 4'd0))
    else $error("active job with no pending block");

  a_new_job_starts_block: assert property (@(posedge clk) disable iff (rst)
    take |=> (sub == 2'd0))
    else $error("new job did not restart at the first output of a block");

  a_last_closes_block: assert property (@(posedge clk) disable iff (rst)
    (emit && job_done) |=> (out_valid && out_last && !job_valid || out_valid && out_last))
    else $error("final output of a job not flagged");

endmodule
`default_nettype wire

### bench/rgb_bilinear_upscale_2x_top_test.sv
// Self-checking bench for the 2x bilinear RGB upscaler: random pixels, random stalls.
module rgb_bilinear_upscale_2x_top_test;

  typedef struct packed {
    logic [10:0] x;
    logic [10:0] y;
    logic [23:0] pix;
    logic        last;
  } upscaled_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  logic [rbu_pkg::PIX_W-1:0]         s_axis_tdata = '0;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  logic [rbu_pkg::OUT_DATA_W-1:0]    m_axis_tdata;
  logic                              m_axis_tlast;
  logic                              cfg_we = 1'b0;
  logic [rbu_pkg::REG_IDX_W-1:0]     cfg_addr = '0;
  logic [rbu_pkg::CFG_W-1:0]         cfg_wdata = '0;

  rgb_bilinear_upscale_2x_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [23:0] in_pixel
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [10:0] out_x, [21:11] out_y, [45:22] out_pixel
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Source pixels waiting to be sent, and upscaled pixels waiting to come out.
  logic [23:0] source_q[$];
  upscaled_t   upscaled_q[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;

  // Shadow of the upscaler state.
  logic [10:0] width_reg = 11'd1024;
  logic [10:0] height_reg = 11'd1024;
  logic [23:0] line_mem[0:rbu_pkg::DEF_MAX_WIDTH-1];
  logic [23:0] left_pix = '0;
  logic [23:0] left_above_pix = '0;
  int          col_cnt = 0;
  int          row_cnt = 0;
  upscaled_t   block_buf[16];
  int          block_cnt;

  function automatic int eff_size(input logic [10:0] v, input int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // Truncating per-channel mean of two (a, b) or four pixels.
  function automatic logic [23:0] mean_pix(input logic [23:0] a, input logic [23:0] b,
                                           input logic [23:0] d, input logic [23:0] e,
                                           input logic four);
    logic [23:0] res;
    logic [9:0]  sum;
    res = '0;
    for (int ch = 0; ch < 3; ch++) begin
      sum = a[ch*8 +: 8] + b[ch*8 +: 8];
      if (four) begin
        sum = sum + d[ch*8 +: 8] + e[ch*8 +: 8];
        res[ch*8 +: 8] = sum[9:2];
      end else begin
        res[ch*8 +: 8] = sum[8:1];
      end
    end
    return res;
  endfunction

  task automatic add_block(input int bx, input int by, input logic [23:0] a,
                           input logic [23:0] b, input logic [23:0] d,
                           input logic [23:0] e);
    logic [10:0] x;
    logic [10:0] y;
    x = 11'(bx * 2);
    y = 11'(by * 2);
    block_buf[block_cnt]     = '{x, y, a, 1'b0};
    block_buf[block_cnt + 1] = '{x + 11'd1, y, mean_pix(a, b, '0, '0, 1'b0), 1'b0};
    block_buf[block_cnt + 2] = '{x, y + 11'd1, mean_pix(a, d, '0, '0, 1'b0), 1'b0};
    block_buf[block_cnt + 3] = '{x + 11'd1, y + 11'd1, mean_pix(a, b, d, e, 1'b1), 1'b0};
    block_cnt = block_cnt + 4;
  endtask

  // Advance the shadow state by one source pixel and queue the blocks it completes.
  task automatic upscale_pixel(input logic [23:0] cur);
    int          w;
    int          h;
    int          c;
    int          r;
    logic [23:0] above;
    upscaled_t   item;
    w = eff_size(width_reg, rbu_pkg::DEF_MAX_WIDTH);
    h = eff_size(height_reg, rbu_pkg::DEF_MAX_HEIGHT);
    c = col_cnt;
    r = row_cnt;
    if (c >= w) c = 0;
    if (r >= h) r = 0;
    above = line_mem[c];
    block_cnt = 0;
    if (r >= 1 && c >= 1) add_block(c - 1, r - 1, left_above_pix, above, left_pix, cur);
    if (r >= 1 && c == w - 1) add_block(c, r - 1, above, above, cur, cur);
    if (r == h - 1 && c >= 1) add_block(c - 1, r, left_pix, cur, left_pix, cur);
    if (r == h - 1 && c == w - 1) add_block(c, r, cur, cur, cur, cur);
    for (int i = 0; i < block_cnt; i++) begin
      item = block_buf[i];
      item.last = (i == block_cnt - 1);
      upscaled_q.push_back(item);
    end
    left_above_pix = above;
    left_pix = cur;
    line_mem[c] = cur;
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_cnt = c;
    row_cnt = r;
  endtask

  task automatic report_mismatch(input string what, input logic [23:0] got,
                                 input logic [23:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    mismatches++;
  endtask

  task automatic check_output();
    upscaled_t want;
    if (upscaled_q.size() == 0) begin
      report_mismatch("unexpected output", m_axis_tdata[45:22], '0);
      return;
    end
    want = upscaled_q.pop_front();
    if (m_axis_tdata[10:0] != want.x)
      report_mismatch("out_x", 24'(m_axis_tdata[10:0]), 24'(want.x));
    if (m_axis_tdata[21:11] != want.y)
      report_mismatch("out_y", 24'(m_axis_tdata[21:11]), 24'(want.y));
    if (m_axis_tdata[45:22] != want.pix)
      report_mismatch("out_pixel", m_axis_tdata[45:22], want.pix);
    if (m_axis_tdata[47:46] != 2'b00)
      report_mismatch("tdata pad", 24'(m_axis_tdata[47:46]), '0);
    if (m_axis_tlast != want.last)
      report_mismatch("tlast", 24'(m_axis_tlast), 24'(want.last));
  endtask

  // Driver: hold a request until accepted, then fetch the next one or idle.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) upscale_pixel(s_axis_tdata);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (source_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tdata <= source_q.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted output, stall at random.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_output();
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic set_idling(input int mode);
    case (mode)
      0: begin
        send_idle_pct = 16;
        recv_idle_pct = 75;
      end
      1: begin
        send_idle_pct = 75;
        recv_idle_pct = 16;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  task automatic write_reg(input logic [rbu_pkg::REG_IDX_W-1:0] idx,
                           input logic [10:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    if (idx == rbu_pkg::REG_IMAGE_WIDTH) width_reg = val;
    else height_reg = val;
    col_cnt = 0;
    row_cnt = 0;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Drain everything, then give row-0 pixels time to leave the pipe.
  task automatic wait_idle();
    do @(negedge clk);
    while (source_q.size() != 0 || s_axis_tvalid || upscaled_q.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  function automatic logic [23:0] rand_pixel();
    logic [23:0] p;
    p = 24'($urandom);
    if ($urandom_range(7) == 0) begin
      for (int ch = 0; ch < 3; ch++) begin
        case ($urandom_range(3))
          0: p[ch*8 +: 8] = 8'h00;
          1: p[ch*8 +: 8] = 8'hFF;
          2: p[ch*8 +: 8] = 8'h01;
          default: p[ch*8 +: 8] = 8'hFE;
        endcase
      end
    end
    return p;
  endfunction

  task automatic push_random(input int n);
    for (int i = 0; i < n; i++) source_q.push_back(rand_pixel());
  endtask

  initial begin
    int random_sent;
    int w;
    int h;
    int n;
    int sel;
    random_sent = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    set_idling(0);

    // 2x2 frame: the last pixel completes all four block kinds.
    write_reg(rbu_pkg::REG_IMAGE_WIDTH, 11'd2);
    write_reg(rbu_pkg::REG_IMAGE_HEIGHT, 11'd2);
    source_q.push_back(24'hFFFFFF);
    source_q.push_back(24'h000000);
    source_q.push_back(24'h010203);
    source_q.push_back(24'hFEFDFC);
    wait_idle();

    // Zero sizes act as one; every pixel is a whole frame.
    write_reg(rbu_pkg::REG_IMAGE_WIDTH, 11'd0);
    write_reg(rbu_pkg::REG_IMAGE_HEIGHT, 11'd0);
    source_q.push_back(24'hFFFFFF);
    source_q.push_back(24'h000001);
    source_q.push_back(24'h800080);
    wait_idle();

    // Single row, wraps into a second frame.
    write_reg(rbu_pkg::REG_IMAGE_WIDTH, 11'd3);
    source_q.push_back(24'h010101);
    source_q.push_back(24'hFEFEFE);
    source_q.push_back(24'hFF00FF);
    source_q.push_back(24'h00FF00);
    wait_idle();

    // Tallest image, a few rows of it.
    write_reg(rbu_pkg::REG_IMAGE_HEIGHT, 11'd1024);
    source_q.push_back(24'h000000);
    source_q.push_back(24'hFFFFFF);
    source_q.push_back(24'h7F7F7F);
    source_q.push_back(24'h808080);
    source_q.push_back(24'h010101);
    source_q.push_back(24'hFFFFFF);
    source_q.push_back(24'hFFFFFF);
    source_q.push_back(24'h000000);
    source_q.push_back(24'h030303);
    wait_idle();

    // Oversized width clamps to the maximum; one full row of bottom-edge blocks.
    write_reg(rbu_pkg::REG_IMAGE_WIDTH, 11'd2047);
    write_reg(rbu_pkg::REG_IMAGE_HEIGHT, 11'd1);
    push_random(rbu_pkg::DEF_MAX_WIDTH);
    wait_idle();

    // Widest exact width, oversized height: row 0 only, nothing comes out.
    write_reg(rbu_pkg::REG_IMAGE_WIDTH, 11'd1024);
    write_reg(rbu_pkg::REG_IMAGE_HEIGHT, 11'd2047);
    push_random(5);
    wait_idle();

    while (random_sent < 450) begin
      set_idling(random_sent < 150 ? 0 : (random_sent < 300 ? 1 : 2));
      sel = $urandom_range(9);
      if (sel == 0) w = 0;
      else if (sel <= 6) w = $urandom_range(1, 6);
      else w = $urandom_range(7, 24);
      h = $urandom_range(0, 5);
      sel = $urandom_range(3);
      if (sel != 1) write_reg(rbu_pkg::REG_IMAGE_WIDTH, 11'(w));
      if (sel != 0) write_reg(rbu_pkg::REG_IMAGE_HEIGHT, 11'(h));
      n = eff_size(width_reg, rbu_pkg::DEF_MAX_WIDTH)
        * eff_size(height_reg, rbu_pkg::DEF_MAX_HEIGHT);
      n = $urandom_range(1, 2 * n + 2);
      if (n > 60) n = 60;
      push_random(n);
      random_sent += n;
      wait_idle();
    end

    repeat (16) @(negedge clk);
    if (upscaled_q.size() != 0)
      report_mismatch("outputs never produced", 24'(upscaled_q.size()), '0);
    if (mismatches == 0) begin
      $display("rgb_bilinear_upscale_2x_top_test passed");
    end else begin
      $display("rgb_bilinear_upscale_2x_top_test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("rgb_bilinear_upscale_2x_top_test failed");
    $finish;
  end

endmodule
